@@ sv/gnd_pkg.sv @@
package gnd_pkg;

  // Sizes of the dispenser and of its item fields.
  localparam int NumSlots   = 8;
  localparam int NumValues  = 8;
  localparam int ValueW     = 16;
  localparam int AmountW    = 20;
  localparam int CountW     = 16;
  localparam int SlotW      = 3;
  localparam int TxW        = 16;
  localparam int PaddrW     = 5;
  localparam int PdataW     = 32;
  localparam int RegAddrLsb = 2;
  localparam int RegIdxW    = 3;

  // The divider retires this many quotient bits per cycle.
  localparam int DivRadixBits = 2;
  localparam int DivCycles    = AmountW / DivRadixBits;
  localparam int DivCntW      = $clog2(DivCycles);

  // Command codes of an input item.
  localparam logic CmdWithdraw = 1'b0;
  localparam logic CmdSet      = 1'b1;

  typedef logic [NumValues-1:0][ValueW-1:0] value_arr_t;

  // Face values after reset, smallest slot in the lowest position.
  localparam value_arr_t ValueReset = {
    16'd500, 16'd200, 16'd100, 16'd50, 16'd20, 16'd10, 16'd5, 16'd1
  };

  typedef struct packed {
    logic               command;
    logic [AmountW-1:0] amount;
    logic [SlotW-1:0]   slot_select;
    logic [CountW-1:0]  new_count;
  } in_item_t;

  typedef struct packed {
    logic              found;
    logic [SlotW-1:0]  paid_slot;
    logic [CountW-1:0] note_number;
    logic              last;
    logic [TxW-1:0]    transaction_id;
  } out_item_t;

  // Request to and response from the shared divider.
  typedef struct packed {
    logic               start;
    logic [AmountW-1:0] dividend;
    logic [ValueW-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [AmountW-1:0] quotient;
    logic [ValueW-1:0]  remainder;
  } div_rsp_t;

  typedef enum logic [2:0] {
    StIdle,
    StSlot,
    StDivide,
    StEmit,
    StFail
  } gnd_state_e;

endpackage

@@ sv/gnd_div.sv @@
module gnd_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gnd_pkg::div_req_t  req_i,
  output gnd_pkg::div_rsp_t  rsp_o
);

  logic                               busy_q, busy_d;
  logic                               done_q, done_d;
  logic [gnd_pkg::DivCntW-1:0]        cnt_q, cnt_d;
  logic [gnd_pkg::AmountW-1:0]        dvd_q, dvd_d;
  logic [gnd_pkg::ValueW-1:0]         rem_q, rem_d;
  logic [gnd_pkg::ValueW-1:0]         dvs_q, dvs_d;

  // Restoring division, DivRadixBits quotient bits per cycle, dividend shifts out
  // at the top while quotient bits shift in at the bottom.
  always_comb begin
    logic [gnd_pkg::ValueW:0]   trial;
    logic [gnd_pkg::ValueW-1:0] part;
    logic [gnd_pkg::AmountW-1:0] shreg;
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    part   = rem_q;
    shreg  = dvd_q;
    for (int k = 0; k < gnd_pkg::DivRadixBits; k++) begin
      trial = {part, shreg[gnd_pkg::AmountW-1]};
      shreg = {shreg[gnd_pkg::AmountW-2:0], 1'b0};
      if (trial >= {1'b0, dvs_q}) begin
        trial    = trial - {1'b0, dvs_q};
        shreg[0] = 1'b1;
      end
      part = trial[gnd_pkg::ValueW-1:0];
    end
    if (busy_q) begin
      dvd_d = shreg;
      rem_d = part;
      if (cnt_q == gnd_pkg::DivCntW'(gnd_pkg::DivCycles - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        cnt_d  = '0;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end else if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.busy      = busy_q;
  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = dvd_q;
  assign rsp_o.remainder = rem_q;

  // A finished division leaves a remainder below a non-zero divisor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && (dvs_q != '0) |-> rem_q < dvs_q)
    else $error("divider remainder not below divisor");

  // A start while idle always begins a division.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start && !busy_q |=> busy_q)
    else $error("divider ignored a start");

  // The done flag is a single-cycle pulse.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("divider done held for more than one cycle");

endmodule

@@ sv/gnd_regs.sv @@
module gnd_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gnd_pkg::PaddrW-1:0]  paddr,
  input  logic [gnd_pkg::PdataW-1:0]  pwdata,
  output logic [gnd_pkg::PdataW-1:0]  prdata,
  output gnd_pkg::value_arr_t         values_o
);

  gnd_pkg::value_arr_t               values_q, values_d;
  logic [gnd_pkg::RegIdxW-1:0]       reg_idx;

  assign reg_idx = paddr[gnd_pkg::RegAddrLsb +: gnd_pkg::RegIdxW];

  // Face value registers, written in the access phase of a write.
  always_comb begin
    values_d = values_q;
    if (psel && penable && pwrite) begin
      values_d[reg_idx] = pwdata[gnd_pkg::ValueW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      values_q <= gnd_pkg::ValueReset;
    end else begin
      values_q <= values_d;
    end
  end

  assign prdata   = gnd_pkg::PdataW'(values_q[reg_idx]);
  assign values_o = values_q;

endmodule

@@ sv/greedy_note_dispenser.sv @@
// Channel   Handshake                Payload      Moves
// in        in_valid_i / in_ready_o  in_item_i    withdraw or restock command
// out       out_valid_o / out_ready_i out_item_o  one dispensed slot or verdict
// config    psel, penable, pwrite    paddr/pwdata face value of one slot
//
// A restock item is written while the sequencer is idle. A withdraw item
// visits the slots from the top, starts a division for each slot with a
// non-zero face value that the walk reaches, then emits one result per used
// slot, or a lone result when none is used; the divider sets the pace.
// Input is taken only while the sequencer is idle; results wait in an output
// register, so a stalled output holds the sequencer in its emit states.
// Reset clears the stock, the transaction counter and all control state, and
// loads the default face values.
module greedy_note_dispenser #(
  parameter int NUM_SLOTS = gnd_pkg::NumSlots
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  gnd_pkg::in_item_t           in_item_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output gnd_pkg::out_item_t          out_item_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gnd_pkg::PaddrW-1:0]  paddr,
  input  logic [gnd_pkg::PdataW-1:0]  pwdata,
  output logic [gnd_pkg::PdataW-1:0]  prdata,
  output logic                        pready
);

  localparam int SlotIdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int UsedW    = $clog2(NUM_SLOTS + 1);

  gnd_pkg::gnd_state_e                state_q, state_d;
  logic [SlotIdxW-1:0]                idx_q, idx_d;
  logic                               walk_end_q, walk_end_d;
  logic [gnd_pkg::AmountW-1:0]        rem_q, rem_d;
  logic [UsedW-1:0]                   used_cnt_q, used_cnt_d;
  logic [UsedW-1:0]                   ptr_q, ptr_d;
  logic [gnd_pkg::TxW-1:0]            tx_q, tx_d;
  logic                               out_valid_q, out_valid_d;
  gnd_pkg::out_item_t                 out_item_q, out_item_d;

  logic [gnd_pkg::CountW-1:0]         count_q [NUM_SLOTS];
  logic [SlotIdxW-1:0]                used_slot_q [NUM_SLOTS];
  logic [gnd_pkg::CountW-1:0]         used_num_q [NUM_SLOTS];

  logic                               stock_we;
  logic [SlotIdxW-1:0]                stock_widx;
  logic [gnd_pkg::CountW-1:0]         stock_wdata;
  logic                               used_we;
  logic [SlotIdxW-1:0]                stock_ridx;
  logic [gnd_pkg::CountW-1:0]         count_rd;
  logic [SlotIdxW-1:0]                emit_slot;
  logic [gnd_pkg::CountW-1:0]         emit_num;
  logic                               emit_last;
  logic                               out_free;
  logic                               take;
  logic [gnd_pkg::ValueW-1:0]         value_sel;

  gnd_pkg::value_arr_t                values;
  gnd_pkg::div_req_t                  div_req;
  gnd_pkg::div_rsp_t                  div_rsp;

  gnd_regs u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .values_o (values)
  );

  assign pready = 1'b1;

  gnd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Lookups of the current slot and of the entry being emitted.
  assign value_sel  = values[gnd_pkg::RegIdxW'(idx_q)];
  assign emit_slot  = used_slot_q[ptr_q[SlotIdxW-1:0]];
  assign emit_num   = used_num_q[ptr_q[SlotIdxW-1:0]];
  assign emit_last  = (UsedW'(ptr_q + 1'b1) == used_cnt_q);
  assign stock_ridx = (state_q == gnd_pkg::StEmit) ? emit_slot : idx_q;
  assign count_rd   = count_q[stock_ridx];
  assign out_free   = !out_valid_q || out_ready_i;
  assign take       = (div_rsp.quotient != '0) &&
                      (div_rsp.quotient <= gnd_pkg::AmountW'(count_rd));

  // Sequencer: take restocks while idle, walk the slots from the top, then emit what was used or a not-found result.
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    walk_end_d  = walk_end_q;
    rem_d       = rem_q;
    used_cnt_d  = used_cnt_q;
    ptr_d       = ptr_q;
    tx_d        = tx_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_item_d  = out_item_q;
    div_req     = '0;
    stock_we    = 1'b0;
    stock_widx  = in_item_i.slot_select[SlotIdxW-1:0];
    stock_wdata = in_item_i.new_count;
    used_we     = 1'b0;
    in_ready_o  = 1'b0;

    case (state_q)
      gnd_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_item_i.command == gnd_pkg::CmdSet) begin
            stock_we = (32'(in_item_i.slot_select) < NUM_SLOTS);
          end else begin
            rem_d      = in_item_i.amount;
            idx_d      = SlotIdxW'(NUM_SLOTS - 1);
            walk_end_d = 1'b0;
            used_cnt_d = '0;
            ptr_d      = '0;
            state_d    = gnd_pkg::StSlot;
          end
        end
      end

      gnd_pkg::StSlot: begin
        if (rem_q == '0) begin
          state_d = gnd_pkg::StEmit;
        end else if (walk_end_q) begin
          state_d = gnd_pkg::StFail;
        end else if (value_sel == '0) begin
          if (idx_q == '0) begin
            walk_end_d = 1'b1;
          end else begin
            idx_d = idx_q - 1'b1;
          end
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = rem_q;
          div_req.divisor  = value_sel;
          state_d          = gnd_pkg::StDivide;
        end
      end

      gnd_pkg::StDivide: begin
        if (div_rsp.done) begin
          // Use the slot only when the whole quotient can be paid from it.
          if (take) begin
            used_we    = 1'b1;
            used_cnt_d = used_cnt_q + 1'b1;
            rem_d      = gnd_pkg::AmountW'(div_rsp.remainder);
          end
          if (idx_q == '0) begin
            walk_end_d = 1'b1;
          end else begin
            idx_d = idx_q - 1'b1;
          end
          state_d = gnd_pkg::StSlot;
        end
      end

      gnd_pkg::StEmit: begin
        if (out_free) begin
          out_valid_d               = 1'b1;
          out_item_d.found          = 1'b1;
          out_item_d.transaction_id = tx_q;
          if (used_cnt_q == '0) begin
            out_item_d.paid_slot   = '0;
            out_item_d.note_number = '0;
            out_item_d.last        = 1'b1;
            tx_d                   = tx_q + 1'b1;
            state_d                = gnd_pkg::StIdle;
          end else begin
            out_item_d.paid_slot   = gnd_pkg::SlotW'(emit_slot);
            out_item_d.note_number = emit_num;
            out_item_d.last        = emit_last;
            stock_we               = 1'b1;
            stock_widx             = emit_slot;
            stock_wdata            = count_rd - emit_num;
            if (emit_last) begin
              tx_d    = tx_q + 1'b1;
              state_d = gnd_pkg::StIdle;
            end else begin
              ptr_d = ptr_q + 1'b1;
            end
          end
        end
      end

      gnd_pkg::StFail: begin
        if (out_free) begin
          out_valid_d               = 1'b1;
          out_item_d.found          = 1'b0;
          out_item_d.paid_slot      = '0;
          out_item_d.note_number    = '0;
          out_item_d.last           = 1'b1;
          out_item_d.transaction_id = '0;
          state_d                   = gnd_pkg::StIdle;
        end
      end

      default: begin
        state_d = gnd_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gnd_pkg::StIdle;
      idx_q       <= '0;
      walk_end_q  <= 1'b0;
      used_cnt_q  <= '0;
      ptr_q       <= '0;
      tx_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      walk_end_q  <= walk_end_d;
      used_cnt_q  <= used_cnt_d;
      ptr_q       <= ptr_d;
      tx_q        <= tx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q      <= rem_d;
    out_item_q <= out_item_d;
  end

  // Note stock, cleared at reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NUM_SLOTS; s++) begin
        count_q[s] <= '0;
      end
    end else if (stock_we) begin
      count_q[stock_widx] <= stock_wdata;
    end
  end

  // List of slots used by the withdraw under way.
  always_ff @(posedge clk_i) begin
    if (used_we) begin
      used_slot_q[used_cnt_q[SlotIdxW-1:0]] <= idx_q;
      used_num_q[used_cnt_q[SlotIdxW-1:0]]  <= div_rsp.quotient[gnd_pkg::CountW-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Emitting a used slot never takes more notes than the stock holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gnd_pkg::StEmit) && (used_cnt_q != '0) |-> count_rd >= emit_num)
    else $error("note stock would underflow");

  // The used list never outgrows the number of slots.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(used_cnt_q) <= NUM_SLOTS)
    else $error("used slot list overflow");

  // A not-found result is a lone, empty one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_item_q.found |->
      out_item_q.last && (out_item_q.note_number == '0) &&
      (out_item_q.transaction_id == '0))
    else $error("malformed not-found result");

  // The divider is only started when it is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

endmodule

@@ test/tb.sv @@
module tb;

  // Cycles allowed for the sequencer to settle after the last result or a restock.
  localparam int SettleCycles = 24;

  logic                        clk_i = 1'b0;
  logic                        rst_ni;
  logic                        in_valid_i;
  logic                        in_ready_o;
  gnd_pkg::in_item_t           in_item_i;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  gnd_pkg::out_item_t          out_item_o;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [gnd_pkg::PaddrW-1:0]  paddr;
  logic [gnd_pkg::PdataW-1:0]  pwdata;
  logic [gnd_pkg::PdataW-1:0]  prdata;
  logic                        pready;

  // Predicted state of the dispenser.
  gnd_pkg::value_arr_t         face_values = gnd_pkg::ValueReset;
  logic [gnd_pkg::CountW-1:0]  stock [gnd_pkg::NumSlots];
  logic [gnd_pkg::TxW-1:0]     tx_count;
  gnd_pkg::out_item_t          expected_payouts[$];

  int unsigned mismatches = 0;
  bit          bursty = 1'b1;
  int unsigned ready_hold = 0;

  greedy_note_dispenser dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Generous limit on the whole run.
  initial begin
    #20_000_000;
    $display("tb NOT OK");
    $finish;
  end

  // Applies one item to the predicted state and queues the payouts it causes.
  function automatic void predict_payout(gnd_pkg::in_item_t item);
    int unsigned                paid;
    int unsigned                quotient;
    int unsigned                n_used;
    bit                         settled;
    logic [gnd_pkg::SlotW-1:0]  used_slot [gnd_pkg::NumSlots];
    logic [gnd_pkg::CountW-1:0] used_num [gnd_pkg::NumSlots];
    gnd_pkg::out_item_t         res;
    paid = 0;
    n_used = 0;
    settled = 1'b0;
    if (item.command == gnd_pkg::CmdSet) begin
      stock[item.slot_select] = item.new_count;
      return;
    end
    // Greedy walk from the largest slot; a slot is used whole or not at all.
    for (int i = gnd_pkg::NumSlots - 1; i >= 0 && !settled; i--) begin
      if (face_values[i] != '0) begin
        quotient = (item.amount - paid) / face_values[i];
        if (quotient > 0 && quotient <= stock[i]) begin
          paid += quotient * face_values[i];
          used_slot[n_used] = gnd_pkg::SlotW'(i);
          used_num[n_used] = gnd_pkg::CountW'(quotient);
          n_used++;
        end
      end
      if (paid == item.amount) begin
        settled = 1'b1;
      end
    end
    res = '0;
    res.last = 1'b1;
    if (!settled) begin
      expected_payouts.push_back(res);
      return;
    end
    res.found = 1'b1;
    res.transaction_id = tx_count;
    if (n_used == 0) begin
      expected_payouts.push_back(res);
    end else begin
      for (int k = 0; k < n_used; k++) begin
        res.paid_slot = used_slot[k];
        res.note_number = used_num[k];
        res.last = (k == n_used - 1);
        expected_payouts.push_back(res);
        stock[used_slot[k]] = stock[used_slot[k]] - used_num[k];
      end
    end
    tx_count = tx_count + 1'b1;
  endfunction

  function automatic void compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Result checker: every accepted payout is matched against the oldest prediction.
  always @(posedge clk_i) begin
    gnd_pkg::out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_payouts.size() == 0) begin
        $error("payout with nothing expected: found %0d slot %0d notes %0d",
               out_item_o.found, out_item_o.paid_slot, out_item_o.note_number);
        mismatches++;
      end else begin
        want = expected_payouts.pop_front();
        compare_field("found", want.found, out_item_o.found);
        compare_field("paid_slot", want.paid_slot, out_item_o.paid_slot);
        compare_field("note_number", want.note_number, out_item_o.note_number);
        compare_field("last", want.last, out_item_o.last);
        compare_field("transaction_id", want.transaction_id, out_item_o.transaction_id);
      end
    end
  end

  // Receiver: random stall bursts while bursty is set.
  always @(posedge clk_i) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      out_ready_i <= 1'b0;
    end else if (bursty && $urandom_range(0, 5) == 0) begin
      ready_hold <= $urandom_range(0, 17);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Sends one item, with an optional idle burst first, and predicts on acceptance.
  task automatic send_item(gnd_pkg::in_item_t item);
    if (bursty && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= item;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
    predict_payout(item);
  endtask

  task automatic send_command(logic cmd, int unsigned amount, int unsigned slot,
                              int unsigned count);
    gnd_pkg::in_item_t item;
    item.command = cmd;
    item.amount = gnd_pkg::AmountW'(amount);
    item.slot_select = gnd_pkg::SlotW'(slot);
    item.new_count = gnd_pkg::CountW'(count);
    send_item(item);
  endtask

  // Lets every expected payout arrive, then lets the sequencer fall idle.
  task automatic wait_for_payouts();
    in_valid_i <= 1'b0;
    while (expected_payouts.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Writes one face value over the configuration port and reads it back.
  task automatic program_face_value(int unsigned idx, logic [gnd_pkg::ValueW-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= gnd_pkg::PaddrW'(idx << gnd_pkg::RegAddrLsb);
    pwdata <= gnd_pkg::PdataW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (!pready);
    face_values[idx] = value;
    penable <= 1'b0;
    pwrite <= 1'b0;
    do begin
      @(posedge clk_i);
    end while (0);
    penable <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (!pready);
    compare_field("prdata", value, prdata[gnd_pkg::ValueW-1:0]);
    // The port goes idle before the next transfer.
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Restocks every slot, the smallest with the largest possible count.
  task automatic test_restock_commands();
    send_command(gnd_pkg::CmdSet, 0, 0, 65535);
    for (int s = 1; s < gnd_pkg::NumSlots; s++) begin
      send_command(gnd_pkg::CmdSet, 0, s, 10);
    end
  endtask

  // One note of each face value: a payout from all eight slots.
  task automatic test_full_payout();
    send_command(gnd_pkg::CmdWithdraw, 886, 0, 0);
    send_command(gnd_pkg::CmdWithdraw, 0, 0, 0);
  endtask

  // The largest slot holds too few notes and is passed over entirely.
  task automatic test_short_slot_skipped();
    send_command(gnd_pkg::CmdSet, 0, 7, 1);
    send_command(gnd_pkg::CmdWithdraw, 1500, 0, 0);
    send_command(gnd_pkg::CmdWithdraw, 65535, 0, 0);
  endtask

  // Failures leave the stock and the transaction counter untouched.
  task automatic test_failed_withdraw();
    send_command(gnd_pkg::CmdWithdraw, 1048575, 7, 65535);
    send_command(gnd_pkg::CmdSet, 1048575, 0, 0);
    send_command(gnd_pkg::CmdWithdraw, 3, 0, 0);
    send_command(gnd_pkg::CmdWithdraw, 0, 0, 0);
    send_command(gnd_pkg::CmdWithdraw, 5, 0, 0);
  endtask

  // Slots with a face value of zero are never paid from.
  task automatic test_zero_denomination();
    for (int s = 0; s < gnd_pkg::NumSlots; s++) begin
      send_command(gnd_pkg::CmdSet, 0, s, 4);
    end
    send_command(gnd_pkg::CmdWithdraw, 65535 + 1000 + 7, 0, 0);
    send_command(gnd_pkg::CmdWithdraw, 2 * 65535 + 300 + 2, 0, 0);
    send_command(gnd_pkg::CmdWithdraw, 4100, 0, 0);
  endtask

  task automatic program_values(int unsigned v0, int unsigned v1, int unsigned v2,
                                int unsigned v3, int unsigned v4, int unsigned v5,
                                int unsigned v6, int unsigned v7);
    int unsigned vals [gnd_pkg::NumSlots];
    vals = '{v0, v1, v2, v3, v4, v5, v6, v7};
    for (int s = 0; s < gnd_pkg::NumSlots; s++) begin
      program_face_value(s, gnd_pkg::ValueW'(vals[s]));
    end
  endtask

  // Random ascending face values, held within sixteen bits.
  task automatic program_ascending_values();
    int unsigned v;
    v = $urandom_range(1, 9);
    for (int s = 0; s < gnd_pkg::NumSlots; s++) begin
      program_face_value(s, gnd_pkg::ValueW'(v));
      v = v + $urandom_range(1, 4000);
      if (v > 65535) begin
        v = 65535;
      end
    end
  endtask

  // Mostly restocks and payable withdrawals, with some wholly random items.
  task automatic run_random_traffic(int unsigned count);
    gnd_pkg::in_item_t item;
    int unsigned       pick;
    int unsigned       top;
    longint unsigned   total;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      item.command = 1'($urandom);
      item.amount = gnd_pkg::AmountW'($urandom);
      item.slot_select = gnd_pkg::SlotW'($urandom);
      item.new_count = gnd_pkg::CountW'($urandom);
      if (pick < 35) begin
        item.command = gnd_pkg::CmdSet;
        if (pick >= 5) begin
          item.new_count = gnd_pkg::CountW'($urandom_range(0, 30));
        end
      end else if (pick < 85) begin
        // Build the amount from notes actually held.
        item.command = gnd_pkg::CmdWithdraw;
        total = 0;
        for (int s = 0; s < gnd_pkg::NumSlots; s++) begin
          if (stock[s] != 0 && $urandom_range(0, 1) == 1) begin
            top = (stock[s] < 6) ? stock[s] : 6;
            total += longint'($urandom_range(1, top)) * face_values[s];
          end
        end
        if (total < (1 << gnd_pkg::AmountW)) begin
          item.amount = gnd_pkg::AmountW'(total);
        end
      end
      send_item(item);
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    in_item_i <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    tx_count = '0;
    for (int s = 0; s < gnd_pkg::NumSlots; s++) begin
      stock[s] = '0;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed cases under the reset face values.
    send_command(gnd_pkg::CmdWithdraw, 7, 0, 0);
    test_restock_commands();
    test_full_payout();
    test_short_slot_skipped();
    test_failed_withdraw();
    run_random_traffic(110);
    wait_for_payouts();

    // Extreme face values, zero slots among them.
    program_values(0, 2, 7, 0, 300, 1000, 0, 65535);
    test_zero_denomination();
    run_random_traffic(110);
    wait_for_payouts();

    program_ascending_values();
    run_random_traffic(120);
    wait_for_payouts();

    // Reset face values again, with no idling on either side.
    program_values(1, 5, 10, 20, 50, 100, 200, 500);
    bursty = 1'b0;
    run_random_traffic(120);
    wait_for_payouts();

    if (mismatches == 0 && expected_payouts.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/gnd_pkg.sv
sv/gnd_div.sv
sv/gnd_regs.sv
sv/greedy_note_dispenser.sv
test/tb.sv
